[hw/rtl/mrtb_pkg.sv]
// ----------------------------------------------------------------------------
// mrtb_pkg
// Shared types, codes and helpers of the memory read tracker with data bursts.
// ----------------------------------------------------------------------------
package mrtb_pkg;

   localparam int TRACKER_DEPTH = 16;
   localparam int ADDR_WIDTH    = 32;

   typedef logic [ADDR_WIDTH-1:0] addr_type;

   localparam logic [2:0] CMD_READ      = 3'd0;
   localparam logic [2:0] CMD_READ_EX   = 3'd1;
   localparam logic [2:0] CMD_DATA_RET  = 3'd2;
   localparam logic [2:0] CMD_WRITE     = 3'd3;

   localparam logic [1:0] KIND_NULL     = 2'd0;
   localparam logic [1:0] KIND_DATA     = 2'd1;
   localparam logic [1:0] KIND_OVERFLOW = 2'd2;

   localparam logic [1:0] CSR_READ_LATENCY = 2'd0;
   localparam logic [1:0] CSR_BURST_LENGTH = 2'd1;
   localparam logic [1:0] CSR_OWN_ID       = 2'd2;
   localparam logic [1:0] CSR_BROADCAST_ID = 2'd3;

   localparam logic [7:0] AGE_MAX    = 8'd255;
   localparam logic [5:0] COUNT_MAX  = 6'd63;
   localparam logic [6:0] BURST_MAX  = 7'd64;

   typedef enum logic [1:0] {
      OP_NONE   = 2'd0,
      OP_INSERT = 2'd1,
      OP_CANCEL = 2'd2,
      OP_AGE    = 2'd3
   } op_type;

   typedef struct packed {
      logic       valid;
      addr_type   addr;
      logic [3:0] id;
      logic [7:0] age;
   } entry_type;

   typedef struct packed {
      op_type     op;
      addr_type   addr;
      logic [3:0] id;
   } cell_cmd_type;

   typedef struct packed {
      logic       req_type;
      logic [2:0] command;
      addr_type   addr;
      logic [3:0] source_id;
      logic       lock;
   } item_type;

   function automatic addr_type to_addr(input logic [31:0] x);
      addr_type a;
      a = '0;
      for (int i = 0; i < ADDR_WIDTH; i++) begin
         if (i < 32) begin
            a[i] = x[i];
         end
      end
      return a;
   endfunction

   function automatic logic [31:0] from_addr(input addr_type a);
      logic [31:0] x;
      x = '0;
      for (int i = 0; i < 32; i++) begin
         if (i < ADDR_WIDTH) begin
            x[i] = a[i];
         end
      end
      return x;
   endfunction

endpackage

[hw/rtl/mrtb_cell.sv]
// ----------------------------------------------------------------------------
// mrtb_cell
// One tracker slot: holds an entry, ages it, takes a new read, and moves the
// entry of its upper neighbor down when a slot at or below it is removed.
// ----------------------------------------------------------------------------
module mrtb_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  mrtb_pkg::cell_cmd_type cmd,
   input  logic                  prev_valid,
   input  logic                  shift_in,
   input  mrtb_pkg::entry_type   upper,
   output mrtb_pkg::entry_type   cur,
   output logic                  shift_out
);

   logic                valid_ff, valid_in;
   mrtb_pkg::addr_type  addr_ff, addr_in;
   logic [3:0]          id_ff, id_in;
   logic [7:0]          age_ff, age_in;
   logic                hit, ins;

   always_comb begin
      cur.valid = valid_ff;
      cur.addr  = addr_ff;
      cur.id    = id_ff;
      cur.age   = age_ff;
      if (cmd.op == mrtb_pkg::OP_AGE && age_ff != mrtb_pkg::AGE_MAX) begin
         cur.age = age_ff + 8'd1;
      end
   end

   assign hit       = (cmd.op == mrtb_pkg::OP_CANCEL) && valid_ff && (addr_ff == cmd.addr);
   assign shift_out = shift_in | hit;
   assign ins       = (cmd.op == mrtb_pkg::OP_INSERT) && !valid_ff && prev_valid;

   always_comb begin
      valid_in = cur.valid;
      addr_in  = cur.addr;
      id_in    = cur.id;
      age_in   = cur.age;
      priority if (shift_out) begin
         valid_in = upper.valid;
         addr_in  = upper.addr;
         id_in    = upper.id;
         age_in   = upper.age;
      end else if (ins) begin
         valid_in = 1'b1;
         addr_in  = cmd.addr;
         id_in    = cmd.id;
         age_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
      id_ff   <= id_in;
      age_ff  <= age_in;
   end

endmodule

[hw/rtl/mrtb_ctrl.sv]
// ----------------------------------------------------------------------------
// mrtb_ctrl
// Configuration registers, burst sequencing, slot commands and result register.
// ----------------------------------------------------------------------------
module mrtb_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [1:0]             csr_index,
   input  logic [7:0]             csr_wdata,
   input  logic                   exec,
   input  mrtb_pkg::item_type     item,
   input  mrtb_pkg::entry_type    head,
   input  logic                   full,
   output mrtb_pkg::cell_cmd_type cmd,
   output logic                   retire,
   output logic                   rsp_valid,
   output logic [1:0]             rsp_kind,
   output logic [3:0]             rsp_target_id,
   output logic [3:0]             rsp_source_out,
   output logic [31:0]            rsp_line_address_out
);

   logic [7:0]         read_latency_ff;
   logic [6:0]         burst_length_ff;
   logic [3:0]         own_id_ff, broadcast_id_ff;

   logic               bursting_ff, bursting_in;
   logic [5:0]         count_ff, count_in;
   mrtb_pkg::addr_type baddr_ff, baddr_in;
   logic [3:0]         bid_ff, bid_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         kind_ff, kind_in;
   logic [3:0]         target_ff, target_in;
   logic [3:0]         source_ff;
   logic [31:0]        addr_out_ff, addr_out_in;

   logic               is_read, is_cancel, bus_tick, final_tick;
   logic [6:0]         len;
   logic [5:0]         len_m1;

   assign is_read   = item.command == mrtb_pkg::CMD_READ ||
                      item.command == mrtb_pkg::CMD_READ_EX;
   assign is_cancel = item.command == mrtb_pkg::CMD_DATA_RET ||
                      item.command == mrtb_pkg::CMD_WRITE;
   assign bus_tick  = exec && item.req_type;

   always_comb begin
      len = burst_length_ff;
      if (burst_length_ff == 7'd0) begin
         len = 7'd1;
      end else if (burst_length_ff > mrtb_pkg::BURST_MAX) begin
         len = mrtb_pkg::BURST_MAX;
      end
   end

   assign len_m1     = 6'(len - 7'd1);
   assign final_tick = count_ff >= len_m1;

   always_comb begin
      cmd.op   = mrtb_pkg::OP_NONE;
      cmd.addr = item.addr;
      cmd.id   = item.source_id;
      if (exec) begin
         if (!item.req_type) begin
            if (is_read && !full) begin
               cmd.op = mrtb_pkg::OP_INSERT;
            end else if (is_cancel) begin
               cmd.op = mrtb_pkg::OP_CANCEL;
            end
         end else if (!bursting_ff) begin
            cmd.op = mrtb_pkg::OP_AGE;
         end
      end
   end

   assign retire = bus_tick && !bursting_ff && head.valid && (head.age >= read_latency_ff);

   always_comb begin
      bursting_in = bursting_ff;
      count_in    = count_ff;
      baddr_in    = baddr_ff;
      bid_in      = bid_ff;
      priority if (retire) begin
         bursting_in = 1'b1;
         count_in    = '0;
         baddr_in    = head.addr;
         bid_in      = head.id;
      end else if (bus_tick && bursting_ff) begin
         if (final_tick) begin
            bursting_in = 1'b0;
            count_in    = '0;
         end else if (item.lock && count_ff != mrtb_pkg::COUNT_MAX) begin
            count_in = count_ff + 6'd1;
         end
      end
   end

   always_comb begin
      rsp_valid_in = 1'b0;
      kind_in      = mrtb_pkg::KIND_NULL;
      target_in    = broadcast_id_ff;
      addr_out_in  = mrtb_pkg::from_addr(baddr_ff);
      priority if (exec && !item.req_type && is_read && full) begin
         rsp_valid_in = 1'b1;
         kind_in      = mrtb_pkg::KIND_OVERFLOW;
         target_in    = item.source_id;
         addr_out_in  = mrtb_pkg::from_addr(item.addr);
      end else if (bus_tick && bursting_ff) begin
         rsp_valid_in = 1'b1;
         if (final_tick) begin
            kind_in   = mrtb_pkg::KIND_DATA;
            target_in = bid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         read_latency_ff <= 8'd10;
         burst_length_ff <= 7'd4;
         own_id_ff       <= 4'd0;
         broadcast_id_ff <= 4'd15;
      end else if (csr_we) begin
         unique case (csr_index)
            mrtb_pkg::CSR_READ_LATENCY: read_latency_ff <= csr_wdata;
            mrtb_pkg::CSR_BURST_LENGTH: burst_length_ff <= csr_wdata[6:0];
            mrtb_pkg::CSR_OWN_ID:       own_id_ff       <= csr_wdata[3:0];
            mrtb_pkg::CSR_BROADCAST_ID: broadcast_id_ff <= csr_wdata[3:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bursting_ff  <= 1'b0;
         count_ff     <= '0;
         baddr_ff     <= '0;
         bid_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         bursting_ff  <= bursting_in;
         count_ff     <= count_in;
         baddr_ff     <= baddr_in;
         bid_ff       <= bid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      target_ff   <= target_in;
      source_ff   <= own_id_ff;
      addr_out_ff <= addr_out_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_kind             = kind_ff;
   assign rsp_target_id        = target_ff;
   assign rsp_source_out       = source_ff;
   assign rsp_line_address_out = addr_out_ff;

endmodule

[hw/rtl/memory_read_tracker_burst_top.sv]
// ----------------------------------------------------------------------------
// memory_read_tracker_burst_top
// Memory side read tracker: logs reads in a row of slot cells kept in arrival
// order, cancels on data return or write, retires the head slot after the
// read latency and runs the data burst on bus ticks.
//
//   channel   ports                                     transfer
//   request   start, busy, req_*                        start && !busy
//   result    rsp_valid, rsp_*                          rsp_valid, one cycle
//   config    csr_we, csr_index, csr_wdata              csr_we
//
// an item is captured, then takes one update of the slot chain,
// whose removal ripple along the cells sets the cycle.
// the result appears in the cycle after the update, for one cycle.
// busy is high for the update cycle only; reset is synchronous and empties
// the tracker at once. no stall on the result side.
// ----------------------------------------------------------------------------
module memory_read_tracker_burst_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_type,
   input  logic [2:0]  req_command,
   input  logic [31:0] req_line_address,
   input  logic [3:0]  req_source_id,
   input  logic        req_lock_granted,
   output logic        rsp_valid,
   output logic [1:0]  rsp_kind,
   output logic [3:0]  rsp_target_id,
   output logic [3:0]  rsp_source_out,
   output logic [31:0] rsp_line_address_out,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_wdata
);

   localparam int D = mrtb_pkg::TRACKER_DEPTH;

   logic                   pending_ff;
   mrtb_pkg::item_type     item_ff, item_in;
   mrtb_pkg::cell_cmd_type cmd;
   logic                   retire;
   mrtb_pkg::entry_type    ent   [D];
   logic                   shift [D];
   logic                   accept;

   assign accept = start && !pending_ff;
   assign busy   = pending_ff;

   always_comb begin
      item_in.req_type  = req_type;
      item_in.command   = req_command;
      item_in.addr      = mrtb_pkg::to_addr(req_line_address);
      item_in.source_id = req_source_id;
      item_in.lock      = req_lock_granted;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 1'b0;
      end else begin
         pending_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
   end

   for (genvar k = 0; k < D; k++) begin : g_cell
      logic                prev_v;
      logic                sh_in;
      mrtb_pkg::entry_type up;

      if (k == 0) begin : g_first
         assign prev_v = 1'b1;
         assign sh_in  = retire;
      end else begin : g_rest
         assign prev_v = ent[k-1].valid;
         assign sh_in  = shift[k-1];
      end

      if (k == D - 1) begin : g_last
         assign up = '0;
      end else begin : g_inner
         assign up = ent[k+1];
      end

      mrtb_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .prev_valid (prev_v),
         .shift_in   (sh_in),
         .upper      (up),
         .cur        (ent[k]),
         .shift_out  (shift[k])
      );
   end

   mrtb_ctrl u_ctrl (
      .clock                (clock),
      .reset                (reset),
      .csr_we               (csr_we),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .exec                 (pending_ff),
      .item                 (item_ff),
      .head                 (ent[0]),
      .full                 (ent[D-1].valid),
      .cmd                  (cmd),
      .retire               (retire),
      .rsp_valid            (rsp_valid),
      .rsp_kind             (rsp_kind),
      .rsp_target_id        (rsp_target_id),
      .rsp_source_out       (rsp_source_out),
      .rsp_line_address_out (rsp_line_address_out)
   );

endmodule

[hw/rtl/mrtb_checker.sv]
// ----------------------------------------------------------------------------
// mrtb_checker
// Port level checks of the read tracker: busy timing and result origin.
// ----------------------------------------------------------------------------
module mrtb_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        req_type,
   input logic [3:0]  req_source_id,
   input logic [31:0] req_line_address,
   input logic        rsp_valid,
   input logic [1:0]  rsp_kind,
   input logic [3:0]  rsp_target_id,
   input logic [31:0] rsp_line_address_out
);

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy missing after transfer");

   a_busy_single: assert property (@(posedge clock) disable iff (reset)
      busy |=> !busy)
      else $error("busy held too long");

   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy) && ($past(req_type, 2) == (rsp_kind != mrtb_pkg::KIND_OVERFLOW)))
      else $error("result without matching transfer");

   a_overflow_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == mrtb_pkg::KIND_OVERFLOW |->
         rsp_target_id == $past(req_source_id, 2) &&
         rsp_line_address_out == $past(req_line_address, 2))
      else $error("overflow result fields wrong");

endmodule

bind memory_read_tracker_burst_top mrtb_checker u_mrtb_checker (
   .clock                (clock),
   .reset                (reset),
   .start                (start),
   .busy                 (busy),
   .req_type             (req_type),
   .req_source_id        (req_source_id),
   .req_line_address     (req_line_address),
   .rsp_valid            (rsp_valid),
   .rsp_kind             (rsp_kind),
   .rsp_target_id        (rsp_target_id),
   .rsp_line_address_out (rsp_line_address_out)
);

[sim/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for memory_read_tracker_burst_top. Reads, read-exclusives,
// cancels and bus ticks go in over the start/busy port. A built-in tracker
// predictor gives the null bursts, data returns and overflows expected on the
// result port, and each result is checked field by field as it comes out.
// Short directed tests come first, then random traffic under changing settings.
// ----------------------------------------------------------------------------
module testbench;

   localparam logic     REQ_BUS        = 1'b0;
   localparam logic     REQ_TICK       = 1'b1;
   localparam logic [2:0] CMD_OTHER    = 3'd4;
   localparam logic [2:0] CMD_UNUSED   = 3'd7;
   localparam int       RANDOM_ITEMS   = 1820;
   localparam int       WATCHDOG_LIMIT = 600;

   typedef struct {
      logic [1:0]  kind;
      logic [3:0]  target;
      logic [3:0]  source;
      logic [31:0] line;
   } bus_out_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start;
   logic        busy;
   logic        req_type;
   logic [2:0]  req_command;
   logic [31:0] req_line_address;
   logic [3:0]  req_source_id;
   logic        req_lock_granted;
   logic        rsp_valid;
   logic [1:0]  rsp_kind;
   logic [3:0]  rsp_target_id;
   logic [3:0]  rsp_source_out;
   logic [31:0] rsp_line_address_out;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [7:0]  csr_wdata;

   // predicted tracker state, slots packed low in insertion order
   int          slots_used;
   logic [31:0] slot_line [mrtb_pkg::TRACKER_DEPTH];
   logic [3:0]  slot_src [mrtb_pkg::TRACKER_DEPTH];
   logic [7:0]  slot_age [mrtb_pkg::TRACKER_DEPTH];
   logic        burst_on;
   logic [5:0]  beat_count;
   logic [31:0] burst_line;
   logic [3:0]  burst_dest;
   logic [7:0]  cfg_latency;
   logic [6:0]  cfg_burst_len;
   logic [3:0]  cfg_own_id;
   logic [3:0]  cfg_bcast_id;

   bus_out_type bus_out_due [$];
   int          fail_count = 0;
   int          quiet_cycles = 0;
   bit          idle_on = 1'b0;

   memory_read_tracker_burst_top DUT (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_type             (req_type),
      .req_command          (req_command),
      .req_line_address     (req_line_address),
      .req_source_id        (req_source_id),
      .req_lock_granted     (req_lock_granted),
      .rsp_valid            (rsp_valid),
      .rsp_kind             (rsp_kind),
      .rsp_target_id        (rsp_target_id),
      .rsp_source_out       (rsp_source_out),
      .rsp_line_address_out (rsp_line_address_out),
      .csr_we               (csr_we),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void expect_out(logic [1:0] kind, logic [3:0] target, logic [31:0] line);
      bus_out_type item;
      item.kind   = kind;
      item.target = target;
      item.source = cfg_own_id;
      item.line   = line;
      bus_out_due = {bus_out_due, item};
   endfunction

   function automatic void drop_slot(int idx);
      for (int k = idx; k < slots_used - 1; k++) begin
         slot_line[k] = slot_line[k + 1];
         slot_src[k]  = slot_src[k + 1];
         slot_age[k]  = slot_age[k + 1];
      end
      slots_used--;
   endfunction

   function automatic void predict_bus_out(logic kind, logic [2:0] cmd, logic [31:0] line,
                                           logic [3:0] src, logic lock);
      int hit;
      int best;
      int len;
      if (kind == REQ_BUS) begin
         if (cmd == mrtb_pkg::CMD_READ || cmd == mrtb_pkg::CMD_READ_EX) begin
            if (slots_used == mrtb_pkg::TRACKER_DEPTH) begin
               expect_out(mrtb_pkg::KIND_OVERFLOW, src, line);
            end else begin
               slot_line[slots_used] = line;
               slot_src[slots_used]  = src;
               slot_age[slots_used]  = '0;
               slots_used++;
            end
         end else if (cmd == mrtb_pkg::CMD_DATA_RET || cmd == mrtb_pkg::CMD_WRITE) begin
            hit = -1;
            for (int k = slots_used - 1; k >= 0; k--) begin
               if (slot_line[k] == line) hit = k;
            end
            if (hit >= 0) drop_slot(hit);
         end
      end else if (burst_on) begin
         len = cfg_burst_len;
         if (len < 1) len = 1;
         else if (len > mrtb_pkg::BURST_MAX) len = mrtb_pkg::BURST_MAX;
         if (int'(beat_count) >= len - 1) begin
            expect_out(mrtb_pkg::KIND_DATA, burst_dest, burst_line);
            burst_on   = 1'b0;
            beat_count = '0;
         end else begin
            expect_out(mrtb_pkg::KIND_NULL, cfg_bcast_id, burst_line);
            if (lock && beat_count < mrtb_pkg::COUNT_MAX) beat_count++;
         end
      end else if (slots_used > 0) begin
         best = 0;
         for (int k = 0; k < slots_used; k++) begin
            if (slot_age[k] < mrtb_pkg::AGE_MAX) slot_age[k]++;
            if (slot_age[k] > slot_age[best]) best = k;
         end
         if (slot_age[best] >= cfg_latency) begin
            burst_line = slot_line[best];
            burst_dest = slot_src[best];
            drop_slot(best);
            burst_on   = 1'b1;
            beat_count = '0;
         end
      end
   endfunction

   function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %h actual %h", $time, field, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin : check_results
      bus_out_type want;
      if (!reset && rsp_valid) begin
         if (bus_out_due.size() == 0) begin
            $display("%0t: result with none expected: kind %0d target %h source %h line %h",
                     $time, rsp_kind, rsp_target_id, rsp_source_out, rsp_line_address_out);
            fail_count++;
         end else begin
            want = bus_out_due.pop_front();
            check_field("kind", want.kind, rsp_kind);
            check_field("target_id", want.target, rsp_target_id);
            check_field("source_out", want.source, rsp_source_out);
            check_field("line_address_out", want.line, rsp_line_address_out);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || csr_we) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("memory_read_tracker_burst_top regression: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // one transfer on the request port, prediction at the accepting edge
   task automatic send_item(input logic kind, input logic [2:0] cmd, input logic [31:0] line,
                            input logic [3:0] src, input logic lock);
      int gap;
      gap = idle_on ? $urandom_range(0, 17) : 0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start            <= 1'b1;
      req_type         <= kind;
      req_command      <= cmd;
      req_line_address <= line;
      req_source_id    <= src;
      req_lock_granted <= lock;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_bus_out(kind, cmd, line, src, lock);
   endtask

   task automatic send_tick(input logic lock);
      send_item(REQ_TICK, 3'($urandom_range(0, 7)), $urandom, 4'($urandom_range(0, 15)), lock);
   endtask

   task automatic send_bus(input logic [2:0] cmd, input logic [31:0] line, input logic [3:0] src);
      send_item(REQ_BUS, cmd, line, src, 1'($urandom_range(0, 1)));
   endtask

   task automatic wait_idle;
      start <= 1'b0;
      while (bus_out_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic program_regs(input logic [7:0] latency, input logic [7:0] burst,
                               input logic [7:0] own, input logic [7:0] bcast);
      logic [1:0] regs [4];
      logic [7:0] vals [4];
      regs = '{mrtb_pkg::CSR_READ_LATENCY, mrtb_pkg::CSR_BURST_LENGTH,
               mrtb_pkg::CSR_OWN_ID, mrtb_pkg::CSR_BROADCAST_ID};
      vals = '{latency, burst, own, bcast};
      for (int i = 0; i < 4; i++) begin
         csr_we    <= 1'b1;
         csr_index <= regs[i];
         csr_wdata <= vals[i];
         @(posedge clock);
      end
      csr_we        <= 1'b0;
      cfg_latency   = latency;
      cfg_burst_len = burst[6:0];
      cfg_own_id    = own[3:0];
      cfg_bcast_id  = bcast[3:0];
   endtask

   task automatic test_burst_and_lock;
      idle_on = 1'b0;
      program_regs(8'd1, 8'd2, 8'hA3, 8'h1C);
      send_bus(mrtb_pkg::CMD_READ, 32'hFFFF_FFFF, 4'd15);
      send_bus(mrtb_pkg::CMD_READ, 32'h0000_0000, 4'd0);
      // equal ages: the first slot retires, no result on that tick
      send_tick(1'b1);
      send_tick(1'b0);
      send_tick(1'b1);
      send_tick(1'b1);
   endtask

   task automatic test_cancel_and_ignore;
      idle_on = 1'b1;
      send_bus(mrtb_pkg::CMD_WRITE, 32'h0000_0000, 4'd7);
      send_bus(mrtb_pkg::CMD_READ_EX, 32'h0000_1234, 4'd9);
      send_bus(mrtb_pkg::CMD_READ, 32'h0000_1234, 4'd4);
      send_bus(mrtb_pkg::CMD_DATA_RET, 32'h0000_1234, 4'd2);
      send_bus(mrtb_pkg::CMD_DATA_RET, 32'h0000_DEAD, 4'd2);
      send_bus(CMD_OTHER, 32'h0000_1234, 4'd4);
      send_bus(CMD_UNUSED, 32'h0000_1234, 4'd4);
      send_tick(1'b1);
      // shorten the running burst to one beat
      wait_idle;
      program_regs(8'd1, 8'd0, 8'h56, 8'h0F);
      send_tick(1'b0);
   endtask

   task automatic test_tracker_overflow;
      idle_on = 1'b0;
      wait_idle;
      program_regs(8'd255, 8'd64, 8'h0F, 8'hF0);
      for (int i = 0; i < mrtb_pkg::TRACKER_DEPTH; i++) begin
         send_bus(mrtb_pkg::CMD_READ, $urandom, 4'(i));
      end
      send_bus(mrtb_pkg::CMD_READ_EX, 32'h8000_0001, 4'hA);
   endtask

   task automatic test_random_traffic;
      int          sent;
      int          phase_items;
      int          tick_pct;
      int          r;
      logic [31:0] pool [6];
      logic [31:0] line;
      logic [7:0]  lat;
      logic [7:0]  blen;
      logic [2:0]  cmd;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         wait_idle;
         case ($urandom_range(0, 7))
            0:       lat = 8'd0;
            1:       lat = 8'd255;
            2:       lat = 8'd1;
            3:       lat = 8'($urandom_range(25, 254));
            default: lat = 8'($urandom_range(2, 24));
         endcase
         case ($urandom_range(0, 9))
            0:       blen = 8'd0;
            1:       blen = 8'd1;
            2:       blen = 8'd64;
            3:       blen = 8'($urandom_range(65, 127));
            4:       blen = 8'($urandom_range(9, 63));
            default: blen = 8'($urandom_range(2, 8));
         endcase
         blen[7] = 1'($urandom_range(0, 1));
         program_regs(lat, blen, 8'($urandom), 8'($urandom));
         idle_on     = $urandom_range(0, 2) != 0;
         tick_pct    = $urandom_range(30, 75);
         phase_items = $urandom_range(100, 180);
         foreach (pool[i]) pool[i] = $urandom;
         pool[0] = $urandom_range(0, 1) ? 32'h0000_0000 : 32'hFFFF_FFFF;
         for (int n = 0; n < phase_items && sent < RANDOM_ITEMS; n++) begin
            if ($urandom_range(0, 79) == 0) wait_idle;
            r = $urandom_range(0, 99);
            if (r < tick_pct) begin
               send_tick($urandom_range(0, 3) != 0);
               sent++;
            end else begin
               r = $urandom_range(0, 99);
               line = $urandom_range(0, 3) != 0 ? pool[$urandom_range(0, 5)] : $urandom;
               if (r < 45) begin
                  cmd = mrtb_pkg::CMD_READ;
               end else if (r < 60) begin
                  cmd = mrtb_pkg::CMD_READ_EX;
               end else if (r < 90) begin
                  cmd = $urandom_range(0, 1) ? mrtb_pkg::CMD_DATA_RET : mrtb_pkg::CMD_WRITE;
                  if (slots_used > 0 && $urandom_range(0, 4) < 3) begin
                     line = slot_line[$urandom_range(0, slots_used - 1)];
                  end
               end else begin
                  cmd = 3'($urandom_range(CMD_OTHER, CMD_UNUSED));
               end
               sent++;
               send_bus(cmd, line, 4'($urandom_range(0, 15)));
            end
         end
      end
   endtask

   initial begin
      start            <= 1'b0;
      req_type         <= REQ_BUS;
      req_command      <= CMD_OTHER;
      req_line_address <= '0;
      req_source_id    <= '0;
      req_lock_granted <= 1'b0;
      csr_we           <= 1'b0;
      csr_index        <= mrtb_pkg::CSR_READ_LATENCY;
      csr_wdata        <= '0;
      slots_used    = 0;
      burst_on      = 1'b0;
      beat_count    = '0;
      burst_line    = '0;
      burst_dest    = '0;
      cfg_latency   = 8'd10;
      cfg_burst_len = 7'd4;
      cfg_own_id    = 4'd0;
      cfg_bcast_id  = 4'd15;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_burst_and_lock;
      test_cancel_and_ignore;
      test_tracker_overflow;
      test_random_traffic;
      wait_idle;
      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("memory_read_tracker_burst_top regression: pass");
      end else begin
         $display("memory_read_tracker_burst_top regression: fail");
      end
      $finish;
   end

endmodule

[sim.f]
hw/rtl/mrtb_pkg.sv
hw/rtl/mrtb_cell.sv
hw/rtl/mrtb_ctrl.sv
hw/rtl/memory_read_tracker_burst_top.sv
hw/rtl/mrtb_checker.sv
sim/testbench.sv
